FILE: design/wqrbk_pkg.sv
// Shared types and codes for the waiting queue with remove-by-key.
// No dependencies; imported by the engine and the top level.
package wqrbk_pkg;

  // Field widths of the request and response words
  localparam int TICKET_IN_BITS = 16;
  localparam int COUNT_OUT_BITS = 5;

  // Action codes
  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_EMPTY     = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  typedef struct packed {
    logic                      action;
    logic [TICKET_IN_BITS-1:0] ticket;
  } req_word_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [COUNT_OUT_BITS-1:0] entry_count;
  } rsp_word_t;

endpackage

FILE: design/wqrbk_engine.sv
// Queue engine: entry memory, occupancy count and the scan/compact sequencer.
// Depends on wqrbk_pkg.
module wqrbk_engine #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TICKET_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  wqrbk_pkg::req_word_t req,
  output logic                 idle,
  output logic                 res_valid,
  input  logic                 res_take,
  output wqrbk_pkg::rsp_word_t res
);
  import wqrbk_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  // Entry memory, head at address 0
  logic [TICKET_BITS-1:0] mem [QUEUE_DEPTH];
  logic [TICKET_BITS-1:0] rdata;

  logic [1:0]             state;
  logic [CW-1:0]          count;
  logic [CW-1:0]          chk;      // index of the entry now in rdata
  logic                   hit;
  logic [TICKET_BITS-1:0] key;
  logic [1:0]             res_status;

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [TICKET_BITS-1:0] wr_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;

  logic [TICKET_BITS-1:0] req_tk;
  logic                   full;
  logic [CW-1:0]          chk_inc;
  logic [CW-1:0]          chk_dec;
  logic                   last;
  logic                   hit_now;

  assign req_tk  = TICKET_BITS'(req.ticket);
  assign full    = (count == CW'(QUEUE_DEPTH));
  assign chk_inc = chk + CW'(1);
  assign chk_dec = chk - CW'(1);
  assign last    = (chk_inc >= count);
  assign hit_now = hit || (rdata == key);

  // Memory port control: append writes at the tail; the scan reads one entry
  // a cycle and, once the match is behind it, shifts each entry up by one.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = req_tk;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (req.action == ACT_APPEND) begin
            if (!full) begin
              wr_en   = 1'b1;
              wr_addr = count[AW-1:0];
            end
          end else if (count != '0) begin
            rd_en = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          wr_en   = 1'b1;
          wr_addr = chk_dec[AW-1:0];
          wr_data = rdata;
        end
        if (!last) begin
          rd_en   = 1'b1;
          rd_addr = chk_inc[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  // Synchronous memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      hit   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            key <= req_tk;
            chk <= '0;
            hit <= 1'b0;
            if (req.action == ACT_APPEND) begin
              state <= S_FIN;
              if (full) begin
                res_status <= STATUS_FULL;
              end else begin
                res_status <= STATUS_DONE;
                count      <= count + CW'(1);
              end
            end else if (count == '0) begin
              res_status <= STATUS_EMPTY;
              state      <= S_FIN;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          hit <= hit_now;
          chk <= chk_inc;
          if (last) begin
            state <= S_FIN;
            if (hit_now) begin
              res_status <= STATUS_DONE;
              count      <= count - CW'(1);
            end else begin
              res_status <= STATUS_NOT_FOUND;
            end
          end
        end
        S_FIN: begin
          if (res_take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle             = (state == S_IDLE);
  assign res_valid        = (state == S_FIN);
  assign res.status       = res_status;
  assign res.entry_count  = COUNT_OUT_BITS'(count);

endmodule

FILE: design/waiting_queue_remove_by_key_top.sv
// Top level of the waiting queue with remove-by-key: handshakes and output stage.
// Depends on wqrbk_pkg and wqrbk_engine.
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid/req_ready  | action, ticket
//   rsp     | out       | rsp_valid/rsp_ready  | status, entry_count
//
// An append, or a remove on an empty queue, goes from idle straight to the
// result. A remove that scans reads every stored entry, at most QUEUE_DEPTH:
// the entry memory has one read port, so the search and compaction pass walk it
// one entry per cycle. Reset empties the queue at once; entries are not cleared.
// A held response sits in the output register; the next request is still
// taken, and its result waits in the engine until the register frees up.
module waiting_queue_remove_by_key_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TICKET_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  wqrbk_pkg::req_word_t req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output wqrbk_pkg::rsp_word_t rsp
);
  import wqrbk_pkg::*;

  logic      eng_idle;
  logic      res_valid;
  logic      res_take;
  rsp_word_t res;

  assign req_ready = eng_idle;
  assign res_take  = res_valid && (!rsp_valid || rsp_ready);

  wqrbk_engine #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TICKET_BITS(TICKET_BITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (req_valid && eng_idle),
    .req      (req),
    .idle     (eng_idle),
    .res_valid(res_valid),
    .res_take (res_take),
    .res      (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) rsp <= res;
  end

endmodule

FILE: verif/waiting_queue_remove_by_key_top_tb.sv
`timescale 1ns / 1ps
// Testbench for waiting_queue_remove_by_key_top: a directed table, then random appends and
// removes, each checked against the table or a predictor. Depends on wqrbk_pkg and the RTL.
module waiting_queue_remove_by_key_top_tb;
  import wqrbk_pkg::*;

  localparam int DEPTH        = 16;
  localparam int TBITS        = 16;
  localparam int RANDOM_WORDS = 375;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 40;

  // One row of the directed table; typed rows carry their response
  typedef struct {
    logic                      action;
    logic [TICKET_IN_BITS-1:0] ticket;
    bit                        typed;
    logic [1:0]                status;
    logic [COUNT_OUT_BITS-1:0] count;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_word_t req       = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_word_t rsp;

  logic [TBITS-1:0] ticket_line[$];  // predicted queue contents, head first
  rsp_word_t        pending_rsp[$];  // responses still owed by the block
  stim_row_t        stim_rows[$];
  int               err_count     = 0;
  int               words_sent    = 0;
  int               words_checked = 0;
  int               status_seen[4] = '{0, 0, 0, 0};
  bit               calm          = 1'b0;  // no idling on either side
  bit               hold_pending  = 1'b0;  // ask the receiver for a long hold-off

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  waiting_queue_remove_by_key_top #(
    .QUEUE_DEPTH(DEPTH),
    .TICKET_BITS(TBITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // Predictor: apply one word to the modeled queue, return its response
  function automatic rsp_word_t serve_word(req_word_t w);
    logic [TBITS-1:0] tk;
    int               hit;
    rsp_word_t        r;
    tk  = w.ticket[TBITS-1:0];
    hit = -1;
    if (w.action == ACT_APPEND) begin
      if (ticket_line.size() >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        ticket_line.push_back(tk);
        r.status = STATUS_DONE;
      end
    end else if (ticket_line.size() == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      // first match from the head wins
      foreach (ticket_line[i]) begin
        if (hit < 0 && ticket_line[i] == tk) hit = i;
      end
      if (hit < 0) begin
        r.status = STATUS_NOT_FOUND;
      end else begin
        ticket_line.delete(hit);
        r.status = STATUS_DONE;
      end
    end
    r.entry_count = COUNT_OUT_BITS'(ticket_line.size());
    return r;
  endfunction

  function automatic void add_row(logic act, logic [TICKET_IN_BITS-1:0] tk, bit typed,
                                  logic [1:0] st, logic [COUNT_OUT_BITS-1:0] cnt);
    stim_row_t row;
    row.action = act;
    row.ticket = tk;
    row.typed  = typed;
    row.status = st;
    row.count  = cnt;
    stim_rows.push_back(row);
  endfunction

  // Directed table: empty removes, extreme tickets, duplicates, a miss, fill to full
  function automatic void load_rows();
    add_row(ACT_REMOVE, 16'h0000, 1'b1, STATUS_EMPTY, 5'd0);
    add_row(ACT_REMOVE, 16'hFFFF, 1'b1, STATUS_EMPTY, 5'd0);
    add_row(ACT_APPEND, 16'h0000, 1'b1, STATUS_DONE, 5'd1);
    add_row(ACT_APPEND, 16'hFFFF, 1'b1, STATUS_DONE, 5'd2);
    add_row(ACT_APPEND, 16'h1234, 1'b1, STATUS_DONE, 5'd3);
    add_row(ACT_APPEND, 16'h0000, 1'b1, STATUS_DONE, 5'd4);
    add_row(ACT_REMOVE, 16'h5555, 1'b1, STATUS_NOT_FOUND, 5'd4);
    // two copies of 0000: head one goes first, then the other
    add_row(ACT_REMOVE, 16'h0000, 1'b0, STATUS_DONE, 5'd0);
    add_row(ACT_REMOVE, 16'h0000, 1'b0, STATUS_DONE, 5'd0);
    for (int k = 0; k < DEPTH - 2; k++) begin
      add_row(ACT_APPEND, 16'hA5A5 ^ 16'(k), 1'b0, STATUS_DONE, 5'd0);
    end
    add_row(ACT_APPEND, 16'h0000, 1'b1, STATUS_FULL, 5'd16);
    // remove the head of a full queue: longest compaction
    add_row(ACT_REMOVE, 16'hFFFF, 1'b0, STATUS_DONE, 5'd0);
  endfunction

  // Random word: stretches that lean toward filling alternate with draining ones
  function automatic req_word_t draw_word(int idx);
    req_word_t w;
    int        lean;
    lean     = ((idx / 40) % 2 == 0) ? 70 : 30;
    w.action = ($urandom_range(99) < lean) ? ACT_APPEND : ACT_REMOVE;
    if (w.action == ACT_REMOVE && ticket_line.size() > 0 && $urandom_range(9) < 7) begin
      w.ticket = ticket_line[$urandom_range(ticket_line.size() - 1)];
    end else if ($urandom_range(2) == 0) begin
      // small pool makes duplicates likely
      w.ticket = 16'($urandom_range(7));
    end else begin
      w.ticket = 16'($urandom);
    end
    return w;
  endfunction

  // Offer one word, after a random gap unless calm; predict once it is taken
  task automatic send_word(req_word_t w, bit typed, rsp_word_t typed_rsp);
    int        gap;
    rsp_word_t predicted;
    gap = calm ? 0 : $urandom_range(8);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (!req_ready);
    predicted = serve_word(w);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
    words_sent++;
  endtask

  // Compare one response word with the oldest one owed
  task automatic check_rsp(rsp_word_t got);
    rsp_word_t want;
    if (pending_rsp.size() == 0) begin
      err_count++;
      $display("%0t: response with none owed: status %0d count %0d",
               $time, got.status, got.entry_count);
      return;
    end
    want = pending_rsp.pop_front();
    words_checked++;
    status_seen[want.status]++;
    if (got.status !== want.status) begin
      err_count++;
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
    end
    if (got.entry_count !== want.entry_count) begin
      err_count++;
      $display("%0t: entry_count expected %0d actual %0d",
               $time, want.entry_count, got.entry_count);
    end
  endtask

  // Request side: reset, directed table, random words, drain, verdict
  initial begin : request_side
    req_word_t w;
    rsp_word_t typed_rsp;
    load_rows();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (stim_rows[i]) begin
      w.action              = stim_rows[i].action;
      w.ticket              = stim_rows[i].ticket;
      typed_rsp.status      = stim_rows[i].status;
      typed_rsp.entry_count = stim_rows[i].count;
      send_word(w, stim_rows[i].typed, typed_rsp);
    end
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= 100 && n < 160);
      if (n == 220) hold_pending = 1'b1;
      send_word(draw_word(n), 1'b0, '0);
    end
    req_valid <= 1'b0;
    calm = 1'b0;
    while (pending_rsp.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words, checked %0d responses, one long receiver hold-off.",
             words_sent, words_checked);
    $display("Responses by status: done %0d, not found %0d, empty %0d, full %0d.",
             status_seen[STATUS_DONE], status_seen[STATUS_NOT_FOUND],
             status_seen[STATUS_EMPTY], status_seen[STATUS_FULL]);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Response side: random stalls, one long hold-off on request
  initial begin : response_side
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = calm ? 0 : $urandom_range(8);
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall        = HOLD_CYCLES;
      end
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      check_rsp(rsp);
    end
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("%0t: run timed out", $time);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
